FILE: src/grid_polarity_zero_cross_tracker_macros.svh
// Assertion macros shared by the grid polarity tracker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef GRID_POLARITY_ZERO_CROSS_TRACKER_MACROS_SVH
`define GRID_POLARITY_ZERO_CROSS_TRACKER_MACROS_SVH

// same-cycle implication
`define GPZCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define GPZCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: src/gpzct_pkg.sv
// Types and constants for the grid polarity and zero-crossing tracker.
// No dependencies; imported by gpzct_core and the top level.
package gpzct_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int THR_W        = 15;
  localparam int CNT10_W      = 10;
  localparam int QUAL_W       = 4;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_W        = CNT10_W + FRAC_BITS;  // filter never overshoots its target
  localparam int CFG_IDX_W    = 3;
  localparam int TDATA_IN_W   = 16;
  localparam int TDATA_OUT_W  = 16;

  localparam logic [QUAL_W-1:0]  QUALIFY_TICKS = 4'd10;
  localparam logic [CNT10_W-1:0] PERIOD_FLOOR  = 10'd10;
  localparam logic [CNT10_W-1:0] TEN_BIT_MAX   = 10'd1023;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CROSSING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CROSSING  = 3'd4;

  typedef struct packed {
    logic [THR_W-1:0]   polarity_threshold;
    logic [THR_W-1:0]   near_zero_threshold;
    logic [CNT10_W-1:0] stuck_limit;
    logic [CNT10_W-1:0] min_crossing_count;
    logic [CNT10_W-1:0] max_crossing_count;
  } cfg_t;

  typedef struct packed {
    logic               polarity_now;
    logic               polarity_qualified;
    logic               rise_cross;
    logic               fall_cross;
    logic [CNT10_W-1:0] period_samples;
  } result_t;

endpackage

FILE: src/gpzct_core.sv
// Tracker state and its per-item next-state logic: slow and fast polarity
// flags, crossing counters and the period low-pass filter. Uses gpzct_pkg.
module gpzct_core #(
  parameter int COUNT_CEILING = 1000,
  parameter int FILTER_SHIFT  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    advance,
  input  logic signed [gpzct_pkg::SAMPLE_W-1:0]   sample,
  input  gpzct_pkg::cfg_t                         cfg,
  output gpzct_pkg::result_t                      result
);
  import gpzct_pkg::*;

  localparam int CNT_W = $clog2(COUNT_CEILING + 1);
  localparam int CMP_W = (CNT_W > CNT10_W) ? CNT_W : CNT10_W;
  localparam logic [CNT_W-1:0] CEIL = CNT_W'(COUNT_CEILING);

  logic                slow_polarity, slow_polarity_next;
  logic [QUAL_W-1:0]   slow_qualify_count, slow_qualify_count_next;
  logic                fast_polarity, fast_polarity_next;
  logic [CNT10_W-1:0]  disagree_count, disagree_count_next;
  logic [CNT_W-1:0]    ticks_since_rise, ticks_since_rise_next;
  logic [CNT_W-1:0]    ticks_since_fall, ticks_since_fall_next;
  logic [CNT10_W-1:0]  latched_period, latched_period_next;
  logic [ACC_W-1:0]    period_filter_acc, period_filter_acc_next;

  logic                rise, fall;
  logic [CNT10_W-1:0]  period;

  always_comb begin
    logic signed [SAMPLE_W:0] s, thr, nz;
    logic                     beyond, forced;
    logic [QUAL_W-1:0]        qual_tmp;
    logic [CNT10_W-1:0]       dis_tmp;
    logic [CNT_W-1:0]         rise_inc, fall_inc;
    logic [CMP_W-1:0]         rise_ext, fall_ext, min_ext, max_ext, cap_ext;
    logic signed [ACC_W:0]    diff, step, acc_sum;

    s   = {sample[SAMPLE_W-1], sample};
    thr = $signed({2'b00, cfg.polarity_threshold});
    nz  = $signed({2'b00, cfg.near_zero_threshold});

    // both crossing counters saturate at the ceiling
    rise_inc = (ticks_since_rise >= CEIL) ? CEIL : ticks_since_rise + 1'b1;
    fall_inc = (ticks_since_fall >= CEIL) ? CEIL : ticks_since_fall + 1'b1;

    // slow flag flips after ten samples in a row beyond the threshold
    beyond   = slow_polarity ? (s <= -thr) : (s >= thr);
    qual_tmp = beyond ? slow_qualify_count + 1'b1 : '0;
    if (qual_tmp >= QUALIFY_TICKS) begin
      slow_qualify_count_next = '0;
      slow_polarity_next      = ~slow_polarity;
    end else begin
      slow_qualify_count_next = qual_tmp;
      slow_polarity_next      = slow_polarity;
    end

    // fast flag: forced over near zero or when stuck against the slow flag
    dis_tmp = (fast_polarity != slow_polarity_next) ? disagree_count + 1'b1 : '0;
    if (fast_polarity) begin
      forced = (slow_polarity_next && (s <= nz)) || (dis_tmp >= cfg.stuck_limit);
    end else begin
      forced = (!slow_polarity_next && (s >= -nz)) || (dis_tmp >= cfg.stuck_limit);
    end
    fast_polarity_next  = forced ? ~fast_polarity : fast_polarity;
    disagree_count_next = forced ? '0 : dis_tmp;

    // crossings; the old fast flag is the previous-tick flag
    rise_ext = CMP_W'(rise_inc);
    fall_ext = CMP_W'(fall_inc);
    min_ext  = CMP_W'(cfg.min_crossing_count);
    max_ext  = CMP_W'(cfg.max_crossing_count);
    cap_ext  = CMP_W'(TEN_BIT_MAX);

    rise = (fast_polarity_next && !fast_polarity && !slow_polarity_next &&
            (rise_ext >= min_ext)) || (rise_ext >= max_ext);
    fall = (!fast_polarity_next && fast_polarity && slow_polarity_next &&
            (fall_ext >= min_ext)) || (fall_ext >= max_ext);

    ticks_since_rise_next = rise ? '0 : rise_inc;
    ticks_since_fall_next = fall ? '0 : fall_inc;
    if (!fall) begin
      latched_period_next = latched_period;
    end else if (fall_ext > cap_ext) begin
      latched_period_next = TEN_BIT_MAX;
    end else begin
      latched_period_next = fall_ext[CNT10_W-1:0];
    end

    // first-order low-pass; floor of the scaled step is an arithmetic shift
    diff    = $signed({1'b0, latched_period_next, {FRAC_BITS{1'b0}}}) -
              $signed({1'b0, period_filter_acc});
    step    = diff >>> FILTER_SHIFT;
    acc_sum = $signed({1'b0, period_filter_acc}) + step;
    period_filter_acc_next = acc_sum[ACC_W-1:0];

    period = period_filter_acc_next[ACC_W-1:FRAC_BITS];
    if (period < PERIOD_FLOOR) begin
      period = PERIOD_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_polarity      <= 1'b0;
      slow_qualify_count <= '0;
      fast_polarity      <= 1'b0;
      disagree_count     <= '0;
      ticks_since_rise   <= '0;
      ticks_since_fall   <= '0;
      latched_period     <= '0;
      period_filter_acc  <= '0;
    end else if (advance) begin
      slow_polarity      <= slow_polarity_next;
      slow_qualify_count <= slow_qualify_count_next;
      fast_polarity      <= fast_polarity_next;
      disagree_count     <= disagree_count_next;
      ticks_since_rise   <= ticks_since_rise_next;
      ticks_since_fall   <= ticks_since_fall_next;
      latched_period     <= latched_period_next;
      period_filter_acc  <= period_filter_acc_next;
    end
  end

  always_comb begin
    result.polarity_now       = fast_polarity_next;
    result.polarity_qualified = slow_polarity_next;
    result.rise_cross         = rise;
    result.fall_cross         = fall;
    result.period_samples     = period;
  end

endmodule

FILE: src/grid_polarity_zero_cross_tracker.sv
// Grid polarity and zero-crossing tracker, top level.
// Path: an accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless m_tready stalls the result register; state updates as an item moves into it.
// Reset (rst, synchronous): config registers to defaults, flags/counters/filter cleared,
// both stages empty. Depends on gpzct_pkg, gpzct_core and the macros header.
module grid_polarity_zero_cross_tracker #(
  parameter int COUNT_CEILING = 1000,
  parameter int FILTER_SHIFT  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [gpzct_pkg::TDATA_IN_W-1:0]       s_tdata,   // [15:0] sample
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [0] polarity_now, [1] polarity_qualified, [2] rise_cross, [3] fall_cross,
  // [13:4] period_samples, [15:14] zero
  output logic [gpzct_pkg::TDATA_OUT_W-1:0]      m_tdata,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gpzct_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gpzct_pkg::THR_W-1:0]            cfg_data
);
  import gpzct_pkg::*;

  `include "grid_polarity_zero_cross_tracker_macros.svh"

  cfg_t                        cfg;
  logic                        in_valid;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        advance;
  result_t                     core_result;
  result_t                     result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polarity_threshold  <= THR_W'(400);
      cfg.near_zero_threshold <= THR_W'(40);
      cfg.stuck_limit         <= CNT10_W'(40);
      cfg.min_crossing_count  <= CNT10_W'(285);
      cfg.max_crossing_count  <= CNT10_W'(500);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLARITY_THR:  cfg.polarity_threshold  <= cfg_data;
        REG_NEAR_ZERO_THR: cfg.near_zero_threshold <= cfg_data;
        REG_STUCK_LIMIT:   cfg.stuck_limit         <= cfg_data[CNT10_W-1:0];
        REG_MIN_CROSSING:  cfg.min_crossing_count  <= cfg_data[CNT10_W-1:0];
        REG_MAX_CROSSING:  cfg.max_crossing_count  <= cfg_data[CNT10_W-1:0];
        default: ;
      endcase
    end
  end

  // item moves on when the result register is empty or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= $signed(s_tdata[SAMPLE_W-1:0]);
    end
  end

  gpzct_core #(
    .COUNT_CEILING (COUNT_CEILING),
    .FILTER_SHIFT  (FILTER_SHIFT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (sample),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign m_tdata = {2'b00, result.period_samples, result.fall_cross, result.rise_cross,
                    result.polarity_qualified, result.polarity_now};

  `GPZCT_ASSERT_NEXT(a_accept_fills, clk, rst, s_tvalid && s_tready, in_valid)
  `GPZCT_ASSERT_NEXT(a_stall_holds, clk, rst, in_valid && !advance,
                     in_valid && $stable(sample))
  `GPZCT_ASSERT_NEXT(a_advance_shows, clk, rst, advance, m_tvalid)
  `GPZCT_ASSERT_NOW(a_period_floor, clk, rst, m_tvalid,
                    result.period_samples >= PERIOD_FLOOR)

endmodule
